// File: hdl/tterm_pkg.sv
// shared constants, types and helpers for the text terminal
`timescale 1ns / 1ps
package tterm_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] GLYPH       = 8'd219;
  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] SPACE       = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] NUM_MAX     = 8'd255;
  localparam logic [7:0] CURSOR_NUM  = 8'd25;
  localparam logic [7:0] CLEAR_NUM   = 8'd2;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LB   = 8'h5b;
  localparam logic [7:0] CH_QM   = 8'h3f;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_UH   = 8'h48;
  localparam logic [7:0] CH_LF_F = 8'h66;
  localparam logic [7:0] CH_UJ   = 8'h4a;
  localparam logic [7:0] CH_LL   = 8'h6c;
  localparam logic [7:0] CH_LH   = 8'h68;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_FIRST  = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_PRIV   = 3'd4;

  localparam logic [2:0] REG_TEXT_COLOR = 3'd0;

  typedef struct packed {
    logic accept;
    logic put;
    logic ptr_zero;
    logic rd_item;
    logic load_read;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic fill_rst;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scroll;
    logic clear;
    logic copy_last;
    logic fill_last;
    logic out_busy;
    logic out_valid;
  } status_t;

  function automatic logic [7:0] add_digit(input logic [7:0] n, input logic [7:0] b);
    logic [11:0] v;
    v = 12'(n) * 12'd10 + 12'(b - CH_0);
    return (v > 12'(NUM_MAX)) ? NUM_MAX : v[7:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

endpackage

// File: hdl/text_terminal_with_escape_parser_unit.sv
// top level of the text terminal with escape parser
`timescale 1ns / 1ps
// Text terminal: one beat in, one beat out. A read goes through the registered read port of
// the screen ram and the result register. A scroll copies the screen cell by cell (read then
// write on the single ram) and then blanks the bottom row; a clear walks all CELLS cells, one
// a cycle. After reset a clearing pass fills the screen with grey spaces while no beat is
// taken; text_color writes are taken at any time.
module text_terminal_with_escape_parser_unit #(
  parameter int COLUMNS = tterm_pkg::DEF_COLUMNS,
  parameter int ROWS    = tterm_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_byte, cell_index
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_data, cursor_row, cursor_column, cursor_shown
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tterm_pkg::cmd_t    cmd;
  tterm_pkg::status_t st;

  assign pready = 1'b1;

  tterm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .in_mode (s_tuser),
    .st      (st),
    .cmd     (cmd)
  );

  tterm_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

endmodule

// File: hdl/tterm_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
module tterm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tterm_ctrl.sv
// sequencing state machine for the text terminal
`timescale 1ns / 1ps
module tterm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              in_mode,
  input  tterm_pkg::status_t st,
  output tterm_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_PUT  = 4'd2;
  localparam logic [3:0] ST_RDI  = 4'd3;
  localparam logic [3:0] ST_RDW  = 4'd4;
  localparam logic [3:0] ST_CPR  = 4'd5;
  localparam logic [3:0] ST_CPW  = 4'd6;
  localparam logic [3:0] ST_FILL = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    s_tready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.fill_rst = 1'b1;
        if (st.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = in_mode ? ST_RDI : ST_PUT;
        end
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        if (st.scroll) begin
          cmd.ptr_zero = 1'b1;
          state_next = ST_CPR;
        end else if (st.clear) begin
          cmd.ptr_zero = 1'b1;
          state_next = ST_FILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDI: begin
        cmd.rd_item = 1'b1;
        state_next = ST_RDW;
      end
      ST_RDW: begin
        cmd.load_read = 1'b1;
        state_next = ST_DONE;
      end
      ST_CPR: begin
        cmd.copy_rd = 1'b1;
        state_next = ST_CPW;
      end
      ST_CPW: begin
        cmd.copy_wr = 1'b1;
        state_next = st.copy_last ? ST_FILL : ST_CPR;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (st.fill_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_PUT || state == ST_RDI))
    else $error("accepted beat did not start work");
  a_copy_then_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CPW && st.copy_last) |=> (state == ST_FILL))
    else $error("scroll copy did not end in bottom row blanking");
  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !st.out_busy) |=> st.out_valid)
    else $error("result not presented");

endmodule

// File: hdl/tterm_dp.sv
// datapath: cursor, escape parser, screen store and result register
`timescale 1ns / 1ps
module tterm_dp #(
  parameter int COLUMNS = tterm_pkg::DEF_COLUMNS,
  parameter int ROWS    = tterm_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  tterm_pkg::cmd_t     cmd,
  output tterm_pkg::status_t  st,
  input  logic [23:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]  text_color;
  logic [4:0]  row;
  logic [6:0]  col;
  logic [2:0]  phase;
  logic [7:0]  first_num, second_num;
  logic        cur_en;
  logic [7:0]  item_char;
  logic [10:0] item_idx;
  logic [AW-1:0] ptr;
  logic [15:0] res_data;
  logic [15:0] out_data;
  logic [4:0]  out_row;
  logic [6:0]  out_col;
  logic        out_en;

  logic [2:0]  nphase;
  logic [7:0]  nfirst, nsecond;
  logic        nen;
  logic [7:0]  col_w, rc_tmp;
  logic [5:0]  row_w;
  logic        pw;
  logic [6:0]  pcol;
  logic [4:0]  prow;
  logic [7:0]  pch;
  logic        scroll, clear;

  logic          we;
  logic [AW-1:0] waddr, raddr, put_addr;
  logic [15:0]   wdata, rdata;
  logic          cfg_wr;

  always_comb begin
    nphase  = phase;
    nfirst  = first_num;
    nsecond = second_num;
    nen     = cur_en;
    col_w   = {1'b0, col};
    row_w   = {1'b0, row};
    rc_tmp  = '0;
    pw      = 1'b0;
    pcol    = col;
    prow    = row;
    pch     = item_char;
    scroll  = 1'b0;
    clear   = 1'b0;
    case (phase)
      tterm_pkg::PH_IDLE: begin
        if (item_char == tterm_pkg::ESC_BYTE) begin
          nphase = tterm_pkg::PH_ESC;
        end else begin
          case (item_char)
            tterm_pkg::CH_LF: begin
              col_w = '0;
              row_w = row_w + 6'd1;
            end
            tterm_pkg::CH_CR: col_w = '0;
            tterm_pkg::CH_TAB: col_w = (col_w + 8'd8) & ~8'd7;
            tterm_pkg::CH_BS: begin
              if (col != 7'd0) begin
                col_w = col_w - 8'd1;
                pw    = 1'b1;
                pcol  = col - 7'd1;
                pch   = tterm_pkg::SPACE;
              end else if (row != 5'd0) begin
                row_w = row_w - 6'd1;
                col_w = 8'(COLUMNS - 1);
                pw    = 1'b1;
                pcol  = 7'(COLUMNS - 1);
                prow  = row - 5'd1;
                pch   = tterm_pkg::SPACE;
              end
            end
            default: begin
              pw    = 1'b1;
              col_w = col_w + 8'd1;
            end
          endcase
          if (col_w >= 8'(COLUMNS)) begin
            col_w = '0;
            row_w = row_w + 6'd1;
          end
          if (row_w >= 6'(ROWS)) begin
            scroll = 1'b1;
            row_w  = 6'(ROWS - 1);
          end
        end
      end
      tterm_pkg::PH_ESC: begin
        if (item_char == tterm_pkg::CH_LB) begin
          nphase  = tterm_pkg::PH_FIRST;
          nfirst  = '0;
          nsecond = '0;
        end else begin
          nphase = tterm_pkg::PH_IDLE;
        end
      end
      tterm_pkg::PH_FIRST: begin
        if (item_char == tterm_pkg::CH_QM) begin
          nphase = tterm_pkg::PH_PRIV;
        end else if (tterm_pkg::is_digit(item_char)) begin
          nfirst = tterm_pkg::add_digit(first_num, item_char);
        end else if (item_char == tterm_pkg::CH_SEMI) begin
          nphase = tterm_pkg::PH_SECOND;
        end else if (item_char == tterm_pkg::CH_UH || item_char == tterm_pkg::CH_LF_F) begin
          rc_tmp = (first_num != 8'd0) ? first_num - 8'd1 : 8'd0;
          row_w  = (rc_tmp >= 8'(ROWS)) ? 6'(ROWS - 1) : rc_tmp[5:0];
          col_w  = '0;
          nphase = tterm_pkg::PH_IDLE;
        end else begin
          if (item_char == tterm_pkg::CH_UJ && first_num == tterm_pkg::CLEAR_NUM) begin
            clear = 1'b1;
            row_w = '0;
            col_w = '0;
          end
          nphase = tterm_pkg::PH_IDLE;
        end
      end
      tterm_pkg::PH_SECOND: begin
        if (tterm_pkg::is_digit(item_char)) begin
          nsecond = tterm_pkg::add_digit(second_num, item_char);
        end else begin
          if (item_char == tterm_pkg::CH_UH || item_char == tterm_pkg::CH_LF_F) begin
            rc_tmp = (first_num != 8'd0) ? first_num - 8'd1 : 8'd0;
            row_w  = (rc_tmp >= 8'(ROWS)) ? 6'(ROWS - 1) : rc_tmp[5:0];
            rc_tmp = (second_num != 8'd0) ? second_num - 8'd1 : 8'd0;
            col_w  = (rc_tmp >= 8'(COLUMNS)) ? 8'(COLUMNS - 1) : rc_tmp;
          end
          nphase = tterm_pkg::PH_IDLE;
        end
      end
      tterm_pkg::PH_PRIV: begin
        if (tterm_pkg::is_digit(item_char)) begin
          nfirst = tterm_pkg::add_digit(first_num, item_char);
        end else begin
          if ((item_char == tterm_pkg::CH_LL || item_char == tterm_pkg::CH_LH) &&
              first_num == tterm_pkg::CURSOR_NUM) begin
            nen = (item_char == tterm_pkg::CH_LH);
          end
          nphase = tterm_pkg::PH_IDLE;
        end
      end
      default: nphase = tterm_pkg::PH_IDLE;
    endcase
  end

  assign put_addr = AW'(32'(prow) * COLUMNS + 32'(pcol));
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = {text_color, tterm_pkg::SPACE};
    if (cmd.put) begin
      we    = pw;
      waddr = put_addr;
      wdata = {text_color, pch};
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.fill_wr) begin
      we    = 1'b1;
    end else if (cmd.fill_rst) begin
      we    = 1'b1;
      wdata = {tterm_pkg::RESET_COLOR, tterm_pkg::SPACE};
    end
  end

  assign raddr = cmd.rd_item ? AW'(item_idx) : AW'(32'(ptr) + COLUMNS);

  tterm_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tterm_pkg::RESET_COLOR;
      row        <= '0;
      col        <= '0;
      phase      <= tterm_pkg::PH_IDLE;
      first_num  <= '0;
      second_num <= '0;
      cur_en     <= 1'b1;
      ptr        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr == tterm_pkg::REG_TEXT_COLOR) begin
        text_color <= pwdata[7:0];
      end
      if (cmd.put) begin
        row        <= row_w[4:0];
        col        <= col_w[6:0];
        phase      <= nphase;
        first_num  <= nfirst;
        second_num <= nsecond;
        cur_en     <= nen;
        if (clear && text_color == 8'd0) text_color <= tterm_pkg::RESET_COLOR;
      end
      if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.copy_wr || cmd.fill_wr || cmd.fill_rst) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_char <= s_tdata[7:0];
      item_idx  <= s_tdata[18:8];
    end
    if (cmd.put) begin
      res_data <= '0;
    end else if (cmd.load_read) begin
      if (32'(item_idx) >= CELLS) begin
        res_data <= '0;
      end else if (cur_en && 32'(item_idx) == 32'(row) * COLUMNS + 32'(col)) begin
        res_data <= {text_color, tterm_pkg::GLYPH};
      end else begin
        res_data <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_data <= res_data;
      out_row  <= row;
      out_col  <= col;
      out_en   <= cur_en;
    end
  end

  assign m_tdata = {3'b000, out_en, out_col, out_row, out_data};
  assign prdata  = (paddr == tterm_pkg::REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  assign st.scroll    = scroll;
  assign st.clear     = clear;
  assign st.copy_last = (ptr == AW'(CELLS - COLUMNS - 1));
  assign st.fill_last = (ptr == AW'(CELLS - 1));
  assign st.out_busy  = m_tvalid && !m_tready;
  assign st.out_valid = m_tvalid;

endmodule
